### src/event_fragment_tracker_macros.svh
// Assertion macros used by the checker file.
`ifndef EVENT_FRAGMENT_TRACKER_MACROS_SVH
`define EVENT_FRAGMENT_TRACKER_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define EFT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define EFT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/eft_pkg.sv
package eft_pkg;

    localparam int SLOTS   = 1024;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int SOURCES = 32;
    localparam int TRIG_W  = 32;
    localparam int MASK_W  = 32;
    localparam int SRC_W   = 5;

    // Only the low SOURCES bits of the enable register take effect.
    localparam logic [MASK_W-1:0] EN_LIMIT = {MASK_W{1'b1}} >> (MASK_W - SOURCES);

    typedef enum logic {
        OP_ARRIVAL = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_DISABLED  = 3'd0,
        ST_ACCEPTED  = 3'd1,
        ST_COMPLETE  = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_EXPIRED   = 3'd4,
        ST_RELEASED  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_EXEC
    } fsm_t;

    typedef struct packed {
        logic [TRIG_W-1:0] tag;
        logic [MASK_W-1:0] mask;
    } slot_entry_t;

endpackage

### src/event_fragment_tracker.sv
// Fragment tracker for event building. After reset the slot table is cleared
// one entry per cycle, so busy stays high until all eft_pkg::SLOTS entries
// are cleared; only then is the first command taken. Each command is one
// read-modify-write of its slot: the slot is read from the table memory at
// the edge that takes start, and any update is written back at the end of
// the EXEC state that follows. The result appears on the result ports for
// exactly one cycle with result_valid high, in the cycle in which busy drops
// again; the receiver cannot stall it, so it must take every result as it
// comes.
// The enable mask may be written through the cfg channel while the block is
// idle; cfg_ready is always high.
module event_fragment_tracker (
    input  logic                         clk,
    input  logic                         rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  logic                         op,
    input  logic [eft_pkg::TRIG_W-1:0]   trigger_number,
    input  logic [eft_pkg::SRC_W-1:0]    source_id,
    // result channel
    output logic                         result_valid,
    output logic [2:0]                   status,
    output logic                         replaced_incomplete,
    output logic [eft_pkg::TRIG_W-1:0]   replaced_trigger,
    output logic [eft_pkg::MASK_W-1:0]   slot_mask,
    // configuration channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [eft_pkg::MASK_W-1:0]   cfg_data
);

    eft_pkg::fsm_t                    state_reg;
    eft_pkg::fsm_t                    state_next;
    logic [eft_pkg::SLOT_W-1:0]       clr_idx_reg;
    logic [eft_pkg::SLOT_W-1:0]       clr_idx_next;
    logic [eft_pkg::MASK_W-1:0]       enable_mask_reg;

    logic                             op_reg;
    logic [eft_pkg::TRIG_W-1:0]       trig_reg;
    logic [eft_pkg::SRC_W-1:0]        src_reg;

    eft_pkg::slot_entry_t             mem [eft_pkg::SLOTS];
    eft_pkg::slot_entry_t             rd_data_reg;

    logic                             mem_we;
    logic [eft_pkg::SLOT_W-1:0]       mem_waddr;
    eft_pkg::slot_entry_t             mem_wdata;

    logic                             accept;
    logic                             exec_we;
    eft_pkg::slot_entry_t             exec_wdata;
    eft_pkg::status_t                 exec_status;
    logic                             exec_repl;
    logic [eft_pkg::MASK_W-1:0]       exec_mask;
    logic [eft_pkg::MASK_W-1:0]       en_eff;
    logic [eft_pkg::MASK_W-1:0]       src_bit;
    logic                             src_enabled;
    logic                             clr_done;

    logic                             result_valid_reg;
    eft_pkg::status_t                 status_reg;
    logic                             repl_reg;
    logic [eft_pkg::TRIG_W-1:0]       repl_trig_reg;
    logic [eft_pkg::MASK_W-1:0]       slot_mask_reg;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign clr_done  = (clr_idx_reg == eft_pkg::SLOT_W'(eft_pkg::SLOTS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            eft_pkg::FSM_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = eft_pkg::FSM_IDLE;
                end
            end
            eft_pkg::FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = eft_pkg::FSM_EXEC;
                end
            end
            eft_pkg::FSM_EXEC:
            begin
                state_next = eft_pkg::FSM_IDLE;
            end
            default:
            begin
                state_next = eft_pkg::FSM_IDLE;
            end
        endcase
    end

    // State outputs and clear sweep control
    always_comb
    begin
        busy         = 1'b1;
        clr_idx_next = clr_idx_reg;
        mem_we       = 1'b0;
        mem_waddr    = trig_reg[eft_pkg::SLOT_W-1:0];
        mem_wdata    = exec_wdata;
        case (state_reg)
            eft_pkg::FSM_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = clr_idx_reg + eft_pkg::SLOT_W'(1);
            end
            eft_pkg::FSM_IDLE:
            begin
                busy = 1'b0;
            end
            eft_pkg::FSM_EXEC:
            begin
                mem_we = exec_we;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= eft_pkg::FSM_CLEAR;
            clr_idx_reg      <= '0;
            enable_mask_reg  <= '1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_idx_reg      <= clr_idx_next;
            result_valid_reg <= (state_reg == eft_pkg::FSM_EXEC);
            if (cfg_valid && cfg_ready)
            begin
                enable_mask_reg <= cfg_data;
            end
        end
    end

    // Capture the command beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            trig_reg <= trigger_number;
            src_reg  <= source_id;
        end
    end

    // Slot table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_data_reg <= mem[trigger_number[eft_pkg::SLOT_W-1:0]];
        end
    end

    assign en_eff      = enable_mask_reg & eft_pkg::EN_LIMIT;
    assign src_bit     = eft_pkg::MASK_W'(1) << src_reg;
    assign src_enabled = (32'(src_reg) < eft_pkg::SOURCES) && ((en_eff & src_bit) != '0);

    // Modify the slot read for the current command
    always_comb
    begin
        exec_status = eft_pkg::ST_DISABLED;
        exec_repl   = 1'b0;
        exec_mask   = rd_data_reg.mask;
        exec_we     = 1'b0;
        exec_wdata  = rd_data_reg;
        if (op_reg == eft_pkg::OP_RELEASE)
        begin
            exec_status     = eft_pkg::ST_RELEASED;
            exec_we         = 1'b1;
            exec_wdata.mask = '0;
        end
        else if (!src_enabled)
        begin
            exec_status = eft_pkg::ST_DISABLED;
        end
        else if (trig_reg == rd_data_reg.tag)
        begin
            if ((rd_data_reg.mask & src_bit) != '0)
            begin
                exec_status = eft_pkg::ST_DUPLICATE;
            end
            else
            begin
                exec_mask       = rd_data_reg.mask | src_bit;
                exec_we         = 1'b1;
                exec_wdata.mask = exec_mask;
                exec_status     = (exec_mask == en_eff) ? eft_pkg::ST_COMPLETE
                                                        : eft_pkg::ST_ACCEPTED;
            end
        end
        else if (trig_reg > rd_data_reg.tag)
        begin
            exec_repl       = (rd_data_reg.mask != '0) && (rd_data_reg.mask != en_eff);
            exec_mask       = src_bit;
            exec_we         = 1'b1;
            exec_wdata.tag  = trig_reg;
            exec_wdata.mask = src_bit;
            exec_status     = (src_bit == en_eff) ? eft_pkg::ST_COMPLETE
                                                  : eft_pkg::ST_ACCEPTED;
        end
        else
        begin
            exec_status = eft_pkg::ST_EXPIRED;
        end
    end

    // Hold the result beat for its one cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == eft_pkg::FSM_EXEC)
        begin
            status_reg    <= exec_status;
            repl_reg      <= exec_repl;
            repl_trig_reg <= rd_data_reg.tag;
            slot_mask_reg <= exec_mask;
        end
    end

    assign result_valid        = result_valid_reg;
    assign status              = status_reg;
    assign replaced_incomplete = repl_reg;
    assign replaced_trigger    = repl_trig_reg;
    assign slot_mask           = slot_mask_reg;

endmodule

### src/eft_checker.sv
`include "event_fragment_tracker_macros.svh"

module eft_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        result_valid,
    input logic [2:0]                  status,
    input logic                        replaced_incomplete
);

    // A taken command raises busy for its EXEC state, then produces its result
    `EFT_ASSERT(a_cmd_gives_result, (start && !busy) |=> busy ##1 result_valid, "missing result beat")

    // A result beat lasts one cycle only
    `EFT_ASSERT(a_result_single, result_valid |=> !result_valid, "result beat repeated")

    // The result cycle is an idle cycle
    `EFT_ASSERT(a_result_idle, result_valid |-> !busy, "result while busy")

    // Only a takeover can flag a replaced event
    `EFT_ASSERT(a_repl_takeover, (result_valid && replaced_incomplete) |-> (status == eft_pkg::ST_ACCEPTED || status == eft_pkg::ST_COMPLETE), "replace flag on non-takeover")

    // The table is being cleared while in reset
    `EFT_ASSERT_ALWAYS(a_busy_in_reset, !rst_n |-> busy, "ready during reset")

endmodule

bind event_fragment_tracker eft_checker u_eft_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .result_valid        (result_valid),
    .status              (status),
    .replaced_incomplete (replaced_incomplete)
);
